@@ src/idll_pkg.sv @@
// shared constants and types for the indexed doubly linked list
package idll_pkg;
  localparam int Capacity = 1024;
  localparam int SlotW = $clog2(Capacity);
  localparam int CountW = SlotW + 1;
  localparam int PosW = 11;
  localparam int OpW = 3;
  localparam int ValW = 32;
  localparam int StatW = 2;

  localparam logic [OpW-1:0] OP_GET = 3'd0;
  localparam logic [OpW-1:0] OP_INS_HEAD = 3'd1;
  localparam logic [OpW-1:0] OP_INS_TAIL = 3'd2;
  localparam logic [OpW-1:0] OP_INS_POS = 3'd3;
  localparam logic [OpW-1:0] OP_DEL_POS = 3'd4;

  localparam logic [StatW-1:0] ST_DONE = 2'd0;
  localparam logic [StatW-1:0] ST_BAD_POS = 2'd1;
  localparam logic [StatW-1:0] ST_FULL = 2'd2;

  typedef logic [SlotW-1:0] slot_t;
endpackage

@@ src/idll_in_if.sv @@
// input channel interface
interface idll_in_if;
  logic                  valid;
  logic                  ready;
  logic [2:0]            op;
  logic [10:0]           position;
  logic signed [31:0]    value;
  modport source (output valid, op, position, value, input ready);
  modport sink (input valid, op, position, value, output ready);
endinterface

@@ src/idll_out_if.sv @@
// result channel interface
interface idll_out_if;
  logic                  valid;
  logic                  ready;
  logic signed [31:0]    read_value;
  logic [1:0]            status;
  modport source (output valid, read_value, status, input ready);
  modport sink (input valid, read_value, status, output ready);
endinterface

@@ src/indexed_doubly_linked_list.sv @@
// indexed doubly linked list: node memories, free stack and walk sequencer
// each walk step issues one memory read; a walk takes at most 511 steps at
// capacity 1024 (half the list)
// throughput: one item at a time; the next transfer is taken only after the
// result has been transferred to the sink
// reset: head, tail, length and slot counters clear; memories hold no reset
module indexed_doubly_linked_list (
  input  logic clk,
  input  logic rst_n,
  idll_in_if.sink    in_ch,
  idll_out_if.source out_ch
);
  import idll_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_POP   = 8'b00000010,
    S_WALK  = 8'b00000100,
    S_LINKS = 8'b00001000,
    S_EXEC  = 8'b00010000,
    S_EXEC2 = 8'b00100000,
    S_VAL   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  logic [ValW-1:0] val_mem [Capacity];
  slot_t nxt_mem [Capacity];
  slot_t prv_mem [Capacity];
  slot_t free_mem [Capacity];

  state_t state_r;
  logic [OpW-1:0] op_r;
  logic [PosW-1:0] pos_r;
  logic [ValW-1:0] val_r;
  logic [CountW-1:0] free_top_r, fresh_r, len_r, steps_r;
  slot_t head_r, tail_r, cur_r, new_r, p_r, n_r;
  logic dir_back_r;
  logic ovalid_r;
  logic [ValW-1:0] ord_r;
  logic [StatW-1:0] ost_r;

  slot_t nxt_rd_r, prv_rd_r, free_rd_r;
  logic [ValW-1:0] val_rd_r;
  slot_t rd_addr;
  logic [CountW-1:0] free_rd_idx;

  logic nxt_we, prv_we, val_we, free_we;
  slot_t nxt_wa, prv_wa, val_wa;
  slot_t nxt_wd, prv_wd;

  // memory ports: node memories share one read address, the free stack reads by its own index; one write each
  always_ff @(posedge clk) begin
    nxt_rd_r <= nxt_mem[rd_addr];
    prv_rd_r <= prv_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
    free_rd_r <= free_mem[free_rd_idx[SlotW-1:0]];
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (val_we) val_mem[val_wa] <= val_r;
    if (free_we) free_mem[free_top_r[SlotW-1:0]] <= cur_r;
  end

  assign free_rd_idx = free_top_r - CountW'(1);
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.read_value = ord_r;
  assign out_ch.status = ost_r;

  logic is_ins, full, walk_back;
  assign is_ins = (op_r == OP_INS_HEAD) || (op_r == OP_INS_TAIL) || (op_r == OP_INS_POS);
  assign full = (len_r == CountW'(Capacity));
  assign walk_back = (pos_r >= PosW'(len_r >> 1));

  // walk read address: start node during setup, then stepping along links
  always_comb begin
    rd_addr = cur_r;
    if (state_r == S_POP) rd_addr = walk_back ? tail_r : head_r;
    else if (state_r == S_WALK && steps_r != '0) rd_addr = dir_back_r ? prv_rd_r : nxt_rd_r;
  end

  // write control for the update steps
  always_comb begin
    nxt_we = 1'b0; prv_we = 1'b0; val_we = 1'b0; free_we = 1'b0;
    nxt_wa = new_r; prv_wa = new_r; val_wa = new_r;
    nxt_wd = '0; prv_wd = '0;
    case (state_r)
      S_EXEC: begin
        case (op_r)
          OP_INS_HEAD: begin
            val_we = 1'b1; prv_we = 1'b1; nxt_we = 1'b1;
            nxt_wd = (len_r == '0) ? slot_t'(0) : head_r;
          end
          OP_INS_TAIL: begin
            val_we = 1'b1; prv_we = 1'b1; nxt_we = 1'b1;
            prv_wd = (len_r == '0) ? slot_t'(0) : tail_r;
          end
          OP_INS_POS: begin
            val_we = 1'b1; prv_we = 1'b1; nxt_we = 1'b1;
            prv_wd = p_r; nxt_wd = cur_r;
          end
          OP_DEL_POS: begin
            free_we = (free_top_r < CountW'(Capacity));
            if (cur_r != head_r) begin
              nxt_we = 1'b1; nxt_wa = p_r; nxt_wd = n_r;
            end
            if (cur_r != tail_r) begin
              prv_we = 1'b1; prv_wa = n_r; prv_wd = p_r;
            end
          end
          default: ;
        endcase
      end
      S_EXEC2: begin
        case (op_r)
          OP_INS_HEAD: if (len_r != '0) begin
            prv_we = 1'b1; prv_wa = head_r; prv_wd = new_r;
          end
          OP_INS_TAIL: if (len_r != '0) begin
            nxt_we = 1'b1; nxt_wa = tail_r; nxt_wd = new_r;
          end
          OP_INS_POS: begin
            nxt_we = 1'b1; nxt_wa = p_r; nxt_wd = new_r;
            prv_we = 1'b1; prv_wa = cur_r; prv_wd = new_r;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_top_r <= '0; fresh_r <= '0; len_r <= '0;
      head_r <= '0; tail_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          op_r <= in_ch.op; pos_r <= in_ch.position; val_r <= in_ch.value;
          ord_r <= '0; ost_r <= ST_DONE;
          state_r <= S_POP;
        end
        S_POP: begin
          // checks, slot allocation and walk setup
          if (op_r == OP_GET || op_r == OP_DEL_POS) begin
            if ({1'b0, pos_r} >= {1'b0, len_r}) begin
              ost_r <= ST_BAD_POS;
              if (op_r == OP_GET) ord_r <= '1;
              state_r <= S_DONE;
            end else if (op_r == OP_DEL_POS && len_r == CountW'(1)) state_r <= S_EXEC;
            else state_r <= S_WALK;
          end else if (is_ins) begin
            if (op_r == OP_INS_POS && {1'b0, pos_r} > {1'b0, len_r}) begin
              ost_r <= ST_BAD_POS;
              state_r <= S_DONE;
            end else if (full) begin
              ost_r <= ST_FULL;
              state_r <= S_DONE;
            end else begin
              if (op_r == OP_INS_POS && pos_r == PosW'(len_r)) op_r <= OP_INS_TAIL;
              else if (op_r == OP_INS_POS && pos_r == '0) op_r <= OP_INS_HEAD;
              state_r <= (op_r == OP_INS_POS && pos_r != PosW'(len_r) && pos_r != '0)
                         ? S_WALK : S_VAL;
              if (free_top_r != '0) free_top_r <= free_rd_idx;
              else fresh_r <= fresh_r + CountW'(1);
            end
          end else state_r <= S_DONE;
          if (!walk_back) begin
            dir_back_r <= 1'b0; cur_r <= head_r; steps_r <= CountW'(pos_r);
          end else begin
            dir_back_r <= 1'b1; cur_r <= tail_r;
            steps_r <= len_r - CountW'(pos_r) - CountW'(1);
          end
          if (free_top_r != '0) new_r <= '0;
          else new_r <= fresh_r[SlotW-1:0];
          if (free_top_r != '0) p_r <= '1; else p_r <= '0;
        end
        S_WALK: begin
          // rd_addr presents the next node; read data valid the cycle after
          if (p_r == '1 && is_ins) begin
            new_r <= free_rd_r; p_r <= '0;
          end
          if (steps_r != '0) begin
            cur_r <= rd_addr;
            steps_r <= steps_r - CountW'(1);
          end else state_r <= S_LINKS;
        end
        S_LINKS: begin
          p_r <= prv_rd_r; n_r <= nxt_rd_r;
          if (op_r == OP_GET) begin
            ord_r <= val_rd_r; state_r <= S_DONE;
          end else state_r <= S_EXEC;
        end
        S_VAL: begin
          if (p_r == '1) new_r <= free_rd_r;
          p_r <= '0;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= S_EXEC2;
          case (op_r)
            OP_DEL_POS: begin
              if (free_top_r < CountW'(Capacity)) free_top_r <= free_top_r + CountW'(1);
              len_r <= len_r - CountW'(1);
              if (len_r == CountW'(1)) begin
                head_r <= '0; tail_r <= '0;
              end else begin
                if (cur_r == head_r) head_r <= n_r;
                if (cur_r == tail_r) tail_r <= p_r;
              end
            end
            default: ;
          endcase
        end
        S_EXEC2: begin
          // old neighbor link written together with the insert's head, tail and length update
          state_r <= S_DONE;
          case (op_r)
            OP_INS_HEAD: begin
              if (len_r == '0) tail_r <= new_r;
              head_r <= new_r; len_r <= len_r + CountW'(1);
            end
            OP_INS_TAIL: begin
              if (len_r == '0) head_r <= new_r;
              tail_r <= new_r; len_r <= len_r + CountW'(1);
            end
            OP_INS_POS: len_r <= len_r + CountW'(1);
            default: ;
          endcase
        end
        S_DONE: begin
          ovalid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

@@ bench/tb_top.sv @@
// self-checking bench for the indexed doubly linked list: list predictor, scoreboard, drivers
module tb_top;
  import idll_pkg::*;

  class list_scoreboard;
    logic signed [31:0] vals[$];
    logic signed [31:0] exp_val[$];
    logic [1:0] exp_st[$];
    int errors;
    int checked;
    int n_full, n_bad, max_len;

    function void note_item(logic [2:0] op, logic [10:0] pos, logic signed [31:0] v);
      logic signed [31:0] rd;
      logic [1:0] st;
      int len;
      int p;
      rd = 0;
      st = ST_DONE;
      len = vals.size();
      p = int'(pos);
      case (op)
        OP_GET: begin
          if (p >= len) begin
            rd = -1;
            st = ST_BAD_POS;
          end else rd = vals[p];
        end
        OP_INS_HEAD: begin
          if (len >= Capacity) st = ST_FULL; else vals.push_front(v);
        end
        OP_INS_TAIL: begin
          if (len >= Capacity) st = ST_FULL; else vals.push_back(v);
        end
        OP_INS_POS: begin
          if (p > len) st = ST_BAD_POS;
          else if (len >= Capacity) st = ST_FULL;
          else vals.insert(p, v);
        end
        OP_DEL_POS: begin
          if (p >= len) st = ST_BAD_POS; else vals.delete(p);
        end
        default: ;
      endcase
      if (st == ST_FULL) n_full++;
      if (st == ST_BAD_POS) n_bad++;
      if (vals.size() > max_len) max_len = vals.size();
      exp_val.push_back(rd);
      exp_st.push_back(st);
    endfunction

    function void check_result(logic signed [31:0] rd, logic [1:0] st);
      logic signed [31:0] ev;
      logic [1:0] es;
      checked++;
      if (exp_val.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result rd=%0d st=%0d", rd, st);
        return;
      end
      ev = exp_val.pop_front();
      es = exp_st.pop_front();
      if (rd !== ev || st !== es) begin
        errors++;
        if (errors <= 10)
          $display("mismatch #%0d: expected rd=%0d st=%0d, got rd=%0d st=%0d",
                   checked, ev, es, rd, st);
      end
    endfunction

    function int pending();
      return exp_val.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  idll_in_if in_ch();
  idll_out_if out_ch();
  list_scoreboard sb = new();
  int cycles = 0;
  int hold_cycles = 0;
  bit stim_done = 1'b0;

  indexed_doubly_linked_list DUT (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_GET;
    in_ch.position = '0;
    in_ch.value = '0;
    out_ch.ready = 1'b0;
  end

  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // monitor and check at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_item(in_ch.op, in_ch.position, in_ch.value);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.read_value, out_ch.status);
    if (cycles > 4000000) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result sink with random stalls and one long hold-off
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        g = gap_len();
        if (g == 0 || $urandom_range(0, 3) == 0) out_ch.ready <= 1'b1;
        else begin
          out_ch.ready <= 1'b0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  task automatic send(logic [2:0] op, int pos, logic signed [31:0] v, int gap);
    repeat (gap) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.op = op;
    in_ch.position = 11'(pos);
    in_ch.value = v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() > 0) @(posedge clk);
  endtask

  function int rand_pos();
    int len;
    int r;
    len = sb.vals.size();
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 2047);
    if (r == 1) return len + $urandom_range(0, 2);
    if (len == 0) return 0;
    return $urandom_range(0, len - 1);
  endfunction

  task automatic rand_item(int ins_weight);
    int r;
    logic [2:0] op;
    r = $urandom_range(0, 99);
    if (r < ins_weight) op = 3'($urandom_range(1, 3));
    else if (r < ins_weight + 25) op = OP_GET;
    else if (r < 98) op = OP_DEL_POS;
    else op = 3'($urandom_range(5, 7));
    send(op, rand_pos(), $urandom(), gap_len());
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // directed: empty-list cases, extremes, every op
    send(OP_GET, 0, 0, 0);
    send(OP_DEL_POS, 0, 0, 0);
    send(OP_INS_POS, 1, 5, 0);
    send(OP_INS_POS, 0, 32'sh7fffffff, 0);
    send(OP_DEL_POS, 0, 0, 0);
    send(OP_INS_HEAD, 0, 32'sh80000000, 0);
    send(OP_INS_TAIL, 2047, -1, 0);
    send(OP_INS_POS, 1, 32'h5555aaaa, 0);
    send(OP_INS_POS, 3, 32'haaaa5555, 0);
    send(OP_INS_POS, 0, 7, 0);
    send(OP_GET, 0, 0, 0);
    send(OP_GET, 4, 0, 0);
    send(OP_GET, 5, 0, 0);
    send(OP_GET, 2047, 0, 0);
    send(OP_INS_POS, 2047, 1, 0);
    send(3'd5, 1, 1, 0);
    send(3'd7, 2047, -1, 0);
    send(OP_DEL_POS, 4, 0, 0);
    send(OP_DEL_POS, 2, 0, 0);
    send(OP_DEL_POS, 0, 0, 0);
    send(OP_GET, 1, 0, 0);
    drain();
    // receiver holds off while sender keeps offering
    hold_cycles = 300;
    for (i = 0; i < 40; i++) rand_item(60);
    drain();
    // random mix, small list
    for (i = 0; i < 50; i++) rand_item(40);
    drain();
    // fill to capacity, exercise full status, then random near full
    while (sb.vals.size() < Capacity) send(3'($urandom_range(1, 2)), 0, $urandom(), 0);
    send(OP_INS_HEAD, 0, 1, 0);
    send(OP_INS_TAIL, 0, 1, 0);
    send(OP_INS_POS, 1024, 1, 0);
    send(OP_INS_POS, 512, 1, 0);
    send(OP_GET, 1023, 0, 0);
    send(OP_GET, 511, 0, 0);
    send(OP_GET, 512, 0, 0);
    send(OP_DEL_POS, 1023, 0, 0);
    for (i = 0; i < 30; i++) rand_item(70);
    for (i = 0; i < 30; i++) rand_item(20);
    drain();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (600) @(posedge clk);
    $display("covered %0d results, peak length %0d, %0d full and %0d bad-position cases",
             sb.checked, sb.max_len, sb.n_full, sb.n_bad);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ indexed_doubly_linked_list.f @@
src/idll_pkg.sv
src/idll_in_if.sv
src/idll_out_if.sv
src/indexed_doubly_linked_list.sv
bench/tb_top.sv
